>>> hw/rtl/ppsrb_pkg.sv
`default_nettype none

package ppsrb_pkg;

   localparam int DEF_PEERS       = 4;
   localparam int DEF_WINDOW      = 16;
   localparam int DEF_HANDLE_BITS = 16;

   localparam int CMD_BITS    = 2;
   localparam int PEER_W      = 2;
   localparam int SEQ_W       = 16;
   localparam int HANDLE_W    = 16;
   localparam int STATUS_W    = 3;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;

   localparam logic [CMD_BITS-1:0] CMD_DATA       = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_CONNECT    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DISCONNECT = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_NONE       = 2'd3;

   localparam logic [STATUS_W-1:0] ST_STORED       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OLD_DUP      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SLOT_DUP     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BEYOND       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FAILED       = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CONNECTED    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_DISCONNECTED = 3'd6;

   localparam logic KIND_DELIVERY = 1'b0;
   localparam logic KIND_STATUS   = 1'b1;

   typedef struct packed {
      logic load;
      logic exec;
      logic read;
      logic send;
   } ctrl_cmd_type;

   typedef struct packed {
      logic ignore;
      logic out_free;
      logic will_release;
      logic next_valid;
   } dp_sts_type;

endpackage

`default_nettype wire

>>> hw/rtl/ppsrb_ram.sv
`default_nettype none

module ppsrb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic [WIDTH-1:0]              wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic      [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ppsrb_ctrl.sv
`default_nettype none

module ppsrb_ctrl
   import ppsrb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire dp_sts_type   sts,
   output ctrl_cmd_type      cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_SEND = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.load = req_tvalid && req_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.ignore) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = sts.will_release ? S_READ : S_IDLE;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (sts.out_free) begin
               cmd.send = 1'b1;
               state_in = sts.next_valid ? S_READ : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ppsrb_dp.sv
`default_nettype none

module ppsrb_dp
   import ppsrb_pkg::*;
#(
   parameter int PEERS       = DEF_PEERS,
   parameter int WINDOW      = DEF_WINDOW,
   parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctrl_cmd_type           cmd,
   output dp_sts_type                  sts,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [CMD_BITS-1:0]    req_tuser,
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int PEER_BITS = (PEERS > 1) ? $clog2(PEERS) : 1;
   localparam int SLOT_BITS = $clog2(WINDOW);
   localparam int SUM_BITS  = SLOT_BITS + 1;
   localparam int ADDR_BITS = $clog2(PEERS * WINDOW);

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(
      input logic [PEER_W-1:0]   peer,
      input logic [SEQ_W-1:0]    seq,
      input logic [HANDLE_W-1:0] handle,
      input logic [STATUS_W-1:0] status
   );
      pack_rsp = {3'b000, status, handle, seq, peer};
   endfunction

   logic [CMD_BITS-1:0] cmd_ff;
   logic [PEER_W-1:0]   peer_ff;
   logic [SEQ_W-1:0]    seq_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic                lastp_ff;
   logic                bad_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= req_tuser;
         peer_ff   <= req_tdata[1:0];
         seq_ff    <= req_tdata[17:2];
         handle_ff <= req_tdata[33:18];
         bad_ff    <= req_tdata[34];
         lastp_ff  <= req_tlast;
      end
   end

   logic [SEQ_W-1:0]     expected_ff [PEERS];
   logic [SEQ_W-1:0]     expected_in [PEERS];
   logic [SLOT_BITS-1:0] head_ff     [PEERS];
   logic [SLOT_BITS-1:0] head_in     [PEERS];
   logic [WINDOW-1:0]    valid_ff    [PEERS];
   logic [WINDOW-1:0]    valid_in    [PEERS];
   logic [PEERS-1:0]     failed_ff;
   logic [PEERS-1:0]     failed_in;

   logic [PEER_BITS-1:0] pidx;
   logic                 peer_ok;
   logic [SEQ_W-1:0]     exp_cur;
   logic [SLOT_BITS-1:0] head_cur;
   logic [SLOT_BITS-1:0] head_nx;
   logic [WINDOW-1:0]    row;
   logic                 fail_path;
   logic [SEQ_W-1:0]     diff;
   logic                 in_win;
   logic [SUM_BITS-1:0]  phys_sum;
   logic [SLOT_BITS-1:0] phys;
   logic [STATUS_W-1:0]  st;
   logic                 store;
   logic                 release_ok;
   logic                 will_release;
   logic                 next_valid;
   logic [HANDLE_BITS-1:0] rd_data;

   assign pidx      = PEER_BITS'(peer_ff);
   assign peer_ok   = ({30'd0, peer_ff} < 32'(PEERS));
   assign exp_cur   = expected_ff[pidx];
   assign head_cur  = head_ff[pidx];
   assign row       = valid_ff[pidx];
   assign fail_path = failed_ff[pidx] || bad_ff;
   assign head_nx   = (head_cur == SLOT_BITS'(WINDOW - 1)) ? '0 : head_cur + 1'b1;

   assign diff     = seq_ff - exp_cur;
   assign in_win   = !diff[SEQ_W-1] && (diff < 16'(WINDOW));
   assign phys_sum = SUM_BITS'(head_cur) + SUM_BITS'(diff[SLOT_BITS-1:0]);
   assign phys     = (phys_sum >= SUM_BITS'(WINDOW)) ?
                     SLOT_BITS'(phys_sum - SUM_BITS'(WINDOW)) : SLOT_BITS'(phys_sum);

   always_comb begin
      st    = ST_STORED;
      store = 1'b0;
      unique case (cmd_ff)
         CMD_DATA: begin
            if (fail_path) begin
               st = ST_FAILED;
            end else if (diff[SEQ_W-1]) begin
               st = ST_OLD_DUP;
            end else if (!in_win) begin
               st = ST_BEYOND;
            end else if (row[phys]) begin
               st = ST_SLOT_DUP;
            end else begin
               st    = ST_STORED;
               store = 1'b1;
            end
         end
         CMD_CONNECT: begin
            st = ST_CONNECTED;
         end
         CMD_DISCONNECT: begin
            st = ST_DISCONNECTED;
         end
         default: begin
            st = ST_STORED;
         end
      endcase
   end

   assign release_ok   = (cmd_ff == CMD_DATA) && !fail_path && lastp_ff;
   assign will_release = release_ok && (row[head_cur] || (store && (phys == head_cur)));
   assign next_valid   = row[head_nx];

   always_comb begin
      expected_in = expected_ff;
      head_in     = head_ff;
      valid_in    = valid_ff;
      failed_in   = failed_ff;
      if (cmd.exec) begin
         unique case (cmd_ff)
            CMD_DATA: begin
               if (fail_path) begin
                  failed_in[pidx] = !lastp_ff;
               end else if (store) begin
                  valid_in[pidx][phys] = 1'b1;
               end
            end
            CMD_CONNECT: begin
               expected_in[pidx] = '0;
               failed_in[pidx]   = 1'b0;
            end
            CMD_DISCONNECT: begin
               valid_in[pidx]  = '0;
               failed_in[pidx] = 1'b0;
            end
            default: begin
            end
         endcase
      end
      if (cmd.send) begin
         valid_in[pidx][head_cur] = 1'b0;
         head_in[pidx]            = head_nx;
         expected_in[pidx]        = exp_cur + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '{default: '0};
         head_ff     <= '{default: '0};
         valid_ff    <= '{default: '0};
         failed_ff   <= '0;
      end else begin
         expected_ff <= expected_in;
         head_ff     <= head_in;
         valid_ff    <= valid_in;
         failed_ff   <= failed_in;
      end
   end

   ppsrb_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (PEERS * WINDOW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.exec && store),
      .wr_addr (ADDR_BITS'(pidx) * ADDR_BITS'(WINDOW) + ADDR_BITS'(phys)),
      .wr_data (HANDLE_BITS'(handle_ff)),
      .rd_en   (cmd.read),
      .rd_addr (ADDR_BITS'(pidx) * ADDR_BITS'(WINDOW) + ADDR_BITS'(head_cur)),
      .rd_data (rd_data)
   );

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_kind_ff;
   logic                  rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec || cmd.send) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_kind_ff <= KIND_STATUS;
         rsp_data_ff <= pack_rsp(peer_ff, (cmd_ff == CMD_DATA) ? seq_ff : '0, '0, st);
         rsp_last_ff <= !will_release;
      end else if (cmd.send) begin
         rsp_kind_ff <= KIND_DELIVERY;
         rsp_data_ff <= pack_rsp(peer_ff, exp_cur, HANDLE_W'(rd_data), ST_STORED);
         rsp_last_ff <= !next_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign sts.ignore       = (cmd_ff == CMD_NONE) || !peer_ok;
   assign sts.out_free     = !rsp_valid_ff || rsp_tready;
   assign sts.will_release = will_release;
   assign sts.next_valid   = next_valid;

`ifndef SYNTHESIS
   a_send_filled: assert property (@(posedge clock) disable iff (reset)
      cmd.send |-> row[head_cur])
      else $error("delivery from an empty slot");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(cmd.exec || cmd.send))
      else $error("pending request overwritten");

   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.send |=> expected_ff[$past(pidx)] == $past(exp_cur) + 16'd1)
      else $error("expected number did not advance");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/per_peer_sequence_reorder_buffer.sv
// A request is taken only in idle, registered, then executed once the output is
// free, loading its status onto rsp (none for CMD_NONE or a peer out of range);
// each in-order delivery then reads the slot RAM and loads the output register.
// Reset: synchronous, active high; clears expected numbers, failed flags,
// window heads and slot valid bits at once; slot RAM contents are not cleared.
`default_nettype none

module per_peer_sequence_reorder_buffer
   import ppsrb_pkg::*;
#(
   parameter int PEERS       = DEF_PEERS,
   parameter int WINDOW      = DEF_WINDOW,
   parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // peer[1:0], seq[17:2], payload_handle[33:18], malformed[34], zero[39:35]
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // command[1:0]
   input  wire logic [CMD_BITS-1:0]    req_tuser,
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // out_peer[1:0], out_seq[17:2], out_handle[33:18], status[36:34], zero[39:37]
   output logic      [RSP_DATA_W-1:0]  rsp_tdata,
   // kind[0]
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   ppsrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ppsrb_dp #(
      .PEERS       (PEERS),
      .WINDOW      (WINDOW),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
